@@ rtl/core/sfd_pkg.sv @@
// Shared types and constants for the frame sync decoder.
`default_nettype none
package sfd_pkg;
	localparam int unsigned FRAME_BYTES = 25;
	localparam int unsigned WIN_CELLS   = FRAME_BYTES - 1;
	localparam int unsigned FILL_W      = $clog2(FRAME_BYTES);
	localparam int unsigned CH_W        = 11;
	localparam int unsigned NUM_CH      = 10;
	localparam int unsigned PAYLOAD_BYTES = 14;

	localparam logic [7:0] SYNC_HEAD = 8'h0F;
	localparam logic [7:0] SYNC_TAIL = 8'h00;

	typedef enum logic [2:0] {
		REG_STICK_CENTER = 3'd0,
		REG_KNOB_OFFSET  = 3'd1,
		REG_STICK_LIMIT  = 3'd2,
		REG_DEAD_BAND    = 3'd3,
		REG_SWITCH_LOW   = 3'd4,
		REG_SWITCH_HIGH  = 3'd5
	} reg_idx_t;

	localparam logic [1:0] SW_UP     = 2'd0;
	localparam logic [1:0] SW_MIDDLE = 2'd1;
	localparam logic [1:0] SW_DOWN   = 2'd2;

	localparam logic [CH_W-1:0] RST_STICK_CENTER = 11'd1024;
	localparam logic [CH_W-1:0] RST_KNOB_OFFSET  = 11'd240;
	localparam logic [CH_W-1:0] RST_STICK_LIMIT  = 11'd800;
	localparam logic [CH_W-1:0] RST_DEAD_BAND    = 11'd5;
	localparam logic [CH_W-1:0] RST_SWITCH_LOW   = 11'd650;
	localparam logic [CH_W-1:0] RST_SWITCH_HIGH  = 11'd1400;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		chan_t stick_center;
		chan_t knob_offset;
		chan_t stick_limit;
		chan_t dead_band;
		chan_t switch_low;
		chan_t switch_high;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] stick_right_x;
		logic signed [11:0] stick_right_y;
		logic signed [11:0] stick_left_y;
		logic signed [11:0] stick_left_x;
		logic [1:0]         switch_a;
		logic [1:0]         switch_b;
		logic [1:0]         switch_c;
		logic [1:0]         switch_d;
		logic signed [11:0] knob_left;
		logic signed [11:0] knob_right;
	} result_t;
endpackage
`default_nettype wire

@@ rtl/core/sfd_cell.sv @@
// One byte cell of the receive window shift chain.
`default_nettype none
module sfd_cell (
	input  wire logic       clk,
	input  wire logic       shift_en,
	input  wire logic [7:0] byte_in,
	output logic [7:0]      byte_q
);
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/sfd_decode.sv @@
// Converts the ten raw channels of a frame into stick, switch and knob values.
`default_nettype none
module sfd_decode
	import sfd_pkg::*;
(
	input  wire chan_t      ch [NUM_CH],
	input  wire cfg_t       cfg,
	output result_t         res
);
	function automatic logic signed [11:0] stick_val(chan_t c, cfg_t k);
		logic signed [11:0] d;
		logic [CH_W-1:0]    mag;
		d   = $signed({1'b0, c}) - $signed({1'b0, k.stick_center});
		mag = d[11] ? CH_W'(-d) : d[CH_W-1:0];
		if (mag < k.dead_band || mag > k.stick_limit) begin
			return 12'sd0;
		end
		return d;
	endfunction

	function automatic logic [1:0] switch_val(chan_t c, cfg_t k);
		if (c < k.switch_low) begin
			return SW_UP;
		end
		if (c > k.switch_high) begin
			return SW_DOWN;
		end
		return SW_MIDDLE;
	endfunction

	always_comb begin
		res.stick_right_x = stick_val(ch[0], cfg);
		res.stick_right_y = stick_val(ch[1], cfg);
		res.stick_left_y  = stick_val(ch[2], cfg);
		res.stick_left_x  = stick_val(ch[3], cfg);
		res.switch_a      = switch_val(ch[4], cfg);
		res.switch_b      = switch_val(ch[5], cfg);
		res.switch_c      = switch_val(ch[6], cfg);
		res.switch_d      = switch_val(ch[7], cfg);
		res.knob_left     = $signed({1'b0, ch[8]}) - $signed({1'b0, cfg.knob_offset});
		res.knob_right    = $signed({1'b0, ch[9]}) - $signed({1'b0, cfg.knob_offset});
	end
endmodule
`default_nettype wire

@@ rtl/core/sbus_frame_sync_decoder.sv @@
// Top level: byte window shift chain, frame sync check and two-stage decode.
// The beat that completes a valid frame is registered into ch_s1 and valid_s1, then decoded into res_q and out_valid.
// Throughput: one byte beat per cycle while in_stall is low, as each accepted beat shifts the byte cells.
// Input stall is raised only while a finished result waits on a stalled output.
// Reset clears the window fill count, the stage valids and restores register defaults.
`default_nettype none
module sbus_frame_sync_decoder
	import sfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_index,
	input  wire logic [10:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic signed [11:0] stick_right_x,
	output logic signed [11:0] stick_right_y,
	output logic signed [11:0] stick_left_y,
	output logic signed [11:0] stick_left_x,
	output logic [1:0]      switch_a,
	output logic [1:0]      switch_b,
	output logic [1:0]      switch_c,
	output logic [1:0]      switch_d,
	output logic signed [11:0] knob_left,
	output logic signed [11:0] knob_right
);
	cfg_t              cfg_q;
	logic [7:0]        win [WIN_CELLS];
	logic [FILL_W-1:0] fill_q;
	logic              advance;
	logic              in_acc;
	logic              frame_hit;
	logic [8*PAYLOAD_BYTES-1:0] payload;
	chan_t             ch_s1 [NUM_CH];
	logic              valid_s1;
	result_t           res_d;
	result_t           res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_center <= RST_STICK_CENTER;
			cfg_q.knob_offset  <= RST_KNOB_OFFSET;
			cfg_q.stick_limit  <= RST_STICK_LIMIT;
			cfg_q.dead_band    <= RST_DEAD_BAND;
			cfg_q.switch_low   <= RST_SWITCH_LOW;
			cfg_q.switch_high  <= RST_SWITCH_HIGH;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STICK_CENTER: cfg_q.stick_center <= cfg_data;
				REG_KNOB_OFFSET:  cfg_q.knob_offset  <= cfg_data;
				REG_STICK_LIMIT:  cfg_q.stick_limit  <= cfg_data;
				REG_DEAD_BAND:    cfg_q.dead_band    <= cfg_data;
				REG_SWITCH_LOW:   cfg_q.switch_low   <= cfg_data;
				REG_SWITCH_HIGH:  cfg_q.switch_high  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;
	assign in_acc   = in_valid && advance;

	genvar gi;
	generate
		for (gi = 0; gi < WIN_CELLS; gi++) begin : g_cell
			if (gi == WIN_CELLS - 1) begin : g_last
				sfd_cell u_cell (
					.clk      (clk),
					.shift_en (in_acc),
					.byte_in  (rx_byte),
					.byte_q   (win[gi])
				);
			end else begin : g_mid
				sfd_cell u_cell (
					.clk      (clk),
					.shift_en (in_acc),
					.byte_in  (win[gi+1]),
					.byte_q   (win[gi])
				);
			end
		end
		for (gi = 0; gi < PAYLOAD_BYTES; gi++) begin : g_pay
			assign payload[8*gi +: 8] = win[gi+1];
		end
	endgenerate

	assign frame_hit = (fill_q == FILL_W'(WIN_CELLS)) && (win[0] == SYNC_HEAD)
		&& (rx_byte == SYNC_TAIL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc) begin
			if (frame_hit) begin
				fill_q <= '0;
			end else if (fill_q != FILL_W'(WIN_CELLS)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s1  <= in_acc && frame_hit;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && frame_hit) begin
			for (int k = 0; k < NUM_CH; k++) begin
				ch_s1[k] <= payload[CH_W*k +: CH_W];
			end
		end
	end

	sfd_decode u_decode (
		.ch  (ch_s1),
		.cfg (cfg_q),
		.res (res_d)
	);

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_d;
		end
	end

	assign stick_right_x = res_q.stick_right_x;
	assign stick_right_y = res_q.stick_right_y;
	assign stick_left_y  = res_q.stick_left_y;
	assign stick_left_x  = res_q.stick_left_x;
	assign switch_a      = res_q.switch_a;
	assign switch_b      = res_q.switch_b;
	assign switch_c      = res_q.switch_c;
	assign switch_d      = res_q.switch_d;
	assign knob_left     = res_q.knob_left;
	assign knob_right    = res_q.knob_right;
endmodule
`default_nettype wire

@@ rtl/core/sfd_checker.sv @@
// Port-level checks for the frame sync decoder and the bind that attaches them.
`default_nettype none
module sfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [11:0] stick_right_x,
	input wire logic [1:0]  switch_a,
	input wire logic [1:0]  switch_b,
	input wire logic [1:0]  switch_c,
	input wire logic [1:0]  switch_d,
	input wire logic [11:0] knob_left
);
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output could move");

	a_result_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without an accepted beat two cycles earlier");

	a_switch_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (switch_a != 2'd3 && switch_b != 2'd3 && switch_c != 2'd3
			&& switch_d != 2'd3))
		else $error("switch position out of range");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(stick_right_x)
			&& $stable(knob_left)))
		else $error("stalled result beat changed");
endmodule

bind sbus_frame_sync_decoder sfd_checker u_sfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.stick_right_x (stick_right_x),
	.switch_a      (switch_a),
	.switch_b      (switch_b),
	.switch_c      (switch_c),
	.switch_d      (switch_d),
	.knob_left     (knob_left)
);
`default_nettype wire
